[rtl/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// shared widths, register map, config and word types for the line follower
// ----------------------------------------------------------------------------
package lfs_pkg;

    // field widths
    localparam int LEVELS_W = 8;
    localparam int LOOK_W   = 10;
    localparam int SPEED_W  = 12;
    localparam int GAIN_W   = 12;
    localparam int RATE_W   = 15;
    localparam int STEP_W   = 12;
    localparam int TURN_W   = 16;
    localparam int LPOS_W   = 12;
    localparam int ANGLE_W  = 16;

    // datapath widths
    localparam int AY_W      = LPOS_W;
    localparam int GS_W      = GAIN_W + SPEED_W;
    localparam int LL_W      = 2 * LOOK_W;
    localparam int SQ_W      = 2 * AY_W;
    localparam int PC_W      = GS_W + AY_W;
    localparam int NUM_SHIFT = 9;
    localparam int NUM_W     = PC_W + NUM_SHIFT;
    localparam int LL_SHIFT  = 8;
    localparam int DEN_W     = LL_W + LL_SHIFT + 1;
    localparam int QUO_W     = 16;
    localparam int OVF_SHIFT = RATE_W - NUM_SHIFT;

    // centroid saturation limits
    localparam int Y_NEG_LIM = 1 << (LPOS_W - 1);
    localparam int Y_POS_LIM = (1 << (LPOS_W - 1)) - 1;

    // register port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_BLACK_LEVEL   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOOKAHEAD     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FORWARD_SPEED = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEER_GAIN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_TURN      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SEARCH_TURN   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SEARCH_STEP   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SEARCH_LIMIT  = 3'd7;

    typedef struct packed {
        logic                black_level;
        logic [LOOK_W-1:0]   lookahead_mm;
        logic [SPEED_W-1:0]  forward_speed;
        logic [GAIN_W-1:0]   steer_gain;
        logic [RATE_W-1:0]   max_turn_rate;
        logic [RATE_W-1:0]   search_turn_rate;
        logic [STEP_W-1:0]   search_step;
        logic [RATE_W-1:0]   search_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        black_level:      1'b1,
        lookahead_mm:     10'd100,
        forward_speed:    12'd300,
        steer_gain:       12'd256,
        max_turn_rate:    15'd8192,
        search_turn_rate: 15'd4096,
        search_step:      12'd41,
        search_limit:     15'd12868
    };

    typedef struct packed {
        logic [LEVELS_W-1:0] sensor_levels;
    } t_scan;

    typedef struct packed {
        logic [SPEED_W-1:0]        speed_out;
        logic signed [TURN_W-1:0]  turn_out;
        logic signed [LPOS_W-1:0]  line_position;
        logic                      line_found;
        logic                      searching;
    } t_steer;

endpackage

[rtl/lfs_stream_if.sv]
// ----------------------------------------------------------------------------
// lfs_stream_if
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface lfs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/lfs_cfg.sv]
// ----------------------------------------------------------------------------
// lfs_cfg
// apb register file holding the steering configuration
// ----------------------------------------------------------------------------
module lfs_cfg
    import lfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BLACK_LEVEL:   r_cfg.black_level      <= pwdata[0];
                REG_LOOKAHEAD:     r_cfg.lookahead_mm     <= pwdata[LOOK_W-1:0];
                REG_FORWARD_SPEED: r_cfg.forward_speed    <= pwdata[SPEED_W-1:0];
                REG_STEER_GAIN:    r_cfg.steer_gain       <= pwdata[GAIN_W-1:0];
                REG_MAX_TURN:      r_cfg.max_turn_rate    <= pwdata[RATE_W-1:0];
                REG_SEARCH_TURN:   r_cfg.search_turn_rate <= pwdata[RATE_W-1:0];
                REG_SEARCH_STEP:   r_cfg.search_step      <= pwdata[STEP_W-1:0];
                REG_SEARCH_LIMIT:  r_cfg.search_limit     <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BLACK_LEVEL:   prdata = PDATA_W'(r_cfg.black_level);
            REG_LOOKAHEAD:     prdata = PDATA_W'(r_cfg.lookahead_mm);
            REG_FORWARD_SPEED: prdata = PDATA_W'(r_cfg.forward_speed);
            REG_STEER_GAIN:    prdata = PDATA_W'(r_cfg.steer_gain);
            REG_MAX_TURN:      prdata = PDATA_W'(r_cfg.max_turn_rate);
            REG_SEARCH_TURN:   prdata = PDATA_W'(r_cfg.search_turn_rate);
            REG_SEARCH_STEP:   prdata = PDATA_W'(r_cfg.search_step);
            REG_SEARCH_LIMIT:  prdata = PDATA_W'(r_cfg.search_limit);
            default:           prdata = '0;
        endcase
    end

endmodule

[rtl/lfs_smul.sv]
// ----------------------------------------------------------------------------
// lfs_smul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module lfs_smul #(
    parameter int A_W = 12,
    parameter int B_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [A_W-1:0]   i_a,
    input  logic [B_W-1:0]   i_b,
    output logic [A_W+B_W-1:0] o_prod,
    output logic             o_done
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     r_a;
    logic [B_W-1:0]     r_b;
    logic [A_W+B_W-1:0] r_prod;
    logic [CNT_W-1:0]   r_cnt;
    logic [A_W:0]       n_sum;

    assign n_sum  = {1'b0, r_prod[A_W+B_W-1:B_W]} + (r_b[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});
    assign o_prod = r_prod;
    assign o_done = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(B_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_prod <= '0;
        end else if (r_cnt != '0) begin
            r_prod <= {n_sum, r_prod[B_W-1:1]};
            r_b    <= r_b >> 1;
        end
    end

endmodule

[rtl/lfs_rdiv.sv]
// ----------------------------------------------------------------------------
// lfs_rdiv
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lfs_rdiv
    import lfs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_done
);

    localparam int SH_W  = DEN_W + QUO_W - 1;
    localparam int REM_W = (NUM_W > SH_W) ? NUM_W : SH_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W:0]   n_diff;

    assign n_diff = {1'b0, r_rem} - {1'b0, r_dsh};
    assign o_quo  = r_quo;
    assign o_done = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(QUO_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= REM_W'(i_num);
            r_dsh <= REM_W'({i_den, {(QUO_W-1){1'b0}}});
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            if (!n_diff[REM_W]) begin
                r_rem <= n_diff[REM_W-1:0];
            end
            r_quo <= {r_quo[QUO_W-2:0], ~n_diff[REM_W]};
            r_dsh <= r_dsh >> 1;
        end
    end

endmodule

[rtl/lfs_core.sv]
// ----------------------------------------------------------------------------
// lfs_core
// scan sequencer: serial centroid, serial multiplies, shared divider, search
// ----------------------------------------------------------------------------
module lfs_core
    import lfs_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int SENSOR_PITCH = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    lfs_stream_if.sink    i_scan,
    lfs_stream_if.source  o_steer
);

    localparam int POS_STEP  = 2 * SENSOR_PITCH * 8;
    localparam int POS_MAX   = (CHANNELS - 1) * SENSOR_PITCH * 8;
    localparam int POS_FIRST = -POS_MAX;
    localparam int SUM_MAX   = CHANNELS * POS_MAX;
    localparam int CSUM_W    = $clog2(SUM_MAX + 1) + 1;
    localparam int CNT_W     = $clog2(CHANNELS + 1);

    localparam logic [1:0] DIR_POS = 2'd1;
    localparam logic [1:0] DIR_NEG = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_DIVY  = 7'b0000100,
        ST_MUL2  = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_DIVT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [LEVELS_W-1:0]       r_lvl;
    logic [CNT_W-1:0]          r_ch;
    logic signed [CSUM_W-1:0]  r_pos;
    logic signed [CSUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]          r_count;
    logic [LPOS_W-1:0]         r_y;
    logic [RATE_W-1:0]         r_mag;
    logic                      r_seen;
    logic [ANGLE_W-1:0]        r_angle;
    logic [1:0]                r_dir;
    logic                      r_ovalid;
    t_steer                    r_out;

    logic                      n_seen;
    logic [ANGLE_W-1:0]        n_angle;
    logic [1:0]                n_dir;
    t_steer                    n_out;
    logic [AY_W-1:0]           n_ay;
    logic [LPOS_W-1:0]         n_y;
    logic [RATE_W-1:0]         n_mag;

    logic                      w_acc;
    logic                      w_neg;
    logic [CSUM_W-1:0]         w_abs;
    logic [QUO_W-1:0]          w_ylim;
    logic [QUO_W-1:0]          w_ysat;
    logic                      w_prep_done;
    logic                      w_y_done;
    logic                      w_out_load;
    logic                      w_search_ok;
    logic [ANGLE_W:0]          w_asum;
    logic [DEN_W-1:0]          w_den;
    logic                      w_ovf;

    logic                      w_sq_load;
    logic [AY_W-1:0]           w_sq_a;
    logic [AY_W-1:0]           w_sq_b;
    logic [SQ_W-1:0]           w_sq_prod;
    logic                      w_sq_done;
    logic [LL_W-1:0]           w_ll_prod;
    logic                      w_ll_done;
    logic [PC_W-1:0]           w_pc_prod;
    logic                      w_pc_done;
    logic                      w_div_load;
    logic [NUM_W-1:0]          w_div_num;
    logic [DEN_W-1:0]          w_div_den;
    logic [QUO_W-1:0]          w_quo;
    logic                      w_div_done;

    assign w_acc        = i_scan.valid && i_scan.ready;
    assign i_scan.ready = (r_state == ST_IDLE);
    assign o_steer.valid = r_ovalid;
    assign o_steer.data  = r_out;

    // centroid magnitude and saturation
    assign w_neg  = r_sum[CSUM_W-1];
    assign w_abs  = w_neg ? CSUM_W'(-r_sum) : CSUM_W'(r_sum);
    assign w_ylim = w_neg ? QUO_W'(Y_NEG_LIM) : QUO_W'(Y_POS_LIM);
    assign w_ysat = (w_quo > w_ylim) ? w_ylim : w_quo;
    assign n_ay   = w_ysat[AY_W-1:0];
    assign n_y    = w_neg ? (LPOS_W'(0) - LPOS_W'(n_ay)) : LPOS_W'(n_ay);

    assign w_prep_done = (r_ch == '0) && w_sq_done && w_ll_done;
    assign w_y_done    = (r_state == ST_DIVY) && w_div_done;
    assign w_out_load  = (r_state == ST_DONE) && (!r_ovalid || o_steer.ready);

    // turn divisor and overflow check
    assign w_den = DEN_W'({w_ll_prod, {LL_SHIFT{1'b0}}}) + DEN_W'(w_sq_prod);
    assign w_ovf = (w_pc_prod >= PC_W'({w_den, {OVF_SHIFT{1'b0}}}));
    assign n_mag = (w_quo > QUO_W'(i_cfg.max_turn_rate)) ? i_cfg.max_turn_rate
                                                         : w_quo[RATE_W-1:0];

    // shared multiplier: gain*speed during scan, y*y afterwards
    assign w_sq_load = w_acc || w_y_done;
    assign w_sq_a    = (r_state == ST_IDLE) ? AY_W'(i_cfg.steer_gain) : n_ay;
    assign w_sq_b    = (r_state == ST_IDLE) ? AY_W'(i_cfg.forward_speed) : n_ay;

    assign w_div_load = ((r_state == ST_PREP) && w_prep_done && (r_count != '0)) ||
                        ((r_state == ST_CHECK) && (w_den != '0) && !w_ovf);
    assign w_div_num  = (r_state == ST_PREP) ? NUM_W'(w_abs[CSUM_W-2:0])
                                             : {w_pc_prod, {NUM_SHIFT{1'b0}}};
    assign w_div_den  = (r_state == ST_PREP) ? DEN_W'(r_count) : w_den;

    lfs_smul #(.A_W(AY_W), .B_W(AY_W)) u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_sq_load),
        .i_a     (w_sq_a),
        .i_b     (w_sq_b),
        .o_prod  (w_sq_prod),
        .o_done  (w_sq_done)
    );

    lfs_smul #(.A_W(LOOK_W), .B_W(LOOK_W)) u_mul_ll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_acc),
        .i_a     (i_cfg.lookahead_mm),
        .i_b     (i_cfg.lookahead_mm),
        .o_prod  (w_ll_prod),
        .o_done  (w_ll_done)
    );

    lfs_smul #(.A_W(GS_W), .B_W(AY_W)) u_mul_pc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_y_done),
        .i_a     (w_sq_prod),
        .i_b     (n_ay),
        .o_prod  (w_pc_prod),
        .o_done  (w_pc_done)
    );

    lfs_rdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_div_load),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_acc) n_state = ST_PREP;
            ST_PREP: begin
                if (w_prep_done) begin
                    n_state = (r_count != '0) ? ST_DIVY : ST_DONE;
                end
            end
            ST_DIVY:  if (w_div_done) n_state = ST_MUL2;
            ST_MUL2:  if (w_sq_done && w_pc_done) n_state = ST_CHECK;
            ST_CHECK: n_state = ((w_den == '0) || w_ovf) ? ST_DONE : ST_DIVT;
            ST_DIVT:  if (w_div_done) n_state = ST_DONE;
            ST_DONE:  if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // lost line search
    assign w_search_ok = r_seen && ((r_dir == DIR_POS) || (r_dir == DIR_NEG)) &&
                         (i_cfg.search_turn_rate != '0) &&
                         (r_angle < ANGLE_W'(i_cfg.search_limit));
    assign w_asum = {1'b0, r_angle} + (ANGLE_W+1)'(i_cfg.search_step);

    always_comb begin
        n_out   = '0;
        n_seen  = r_seen;
        n_angle = r_angle;
        n_dir   = r_dir;
        if (r_count != '0) begin
            n_out.speed_out     = i_cfg.forward_speed;
            n_out.line_position = r_y;
            n_out.line_found    = 1'b1;
            n_out.turn_out      = r_y[LPOS_W-1] ? (TURN_W'(0) - TURN_W'(r_mag))
                                                : TURN_W'(r_mag);
            n_seen  = 1'b1;
            n_angle = '0;
            if (r_mag != '0) begin
                n_dir = r_y[LPOS_W-1] ? DIR_NEG : DIR_POS;
            end
        end else if (w_search_ok) begin
            n_out.searching = 1'b1;
            n_out.turn_out  = (r_dir == DIR_POS) ? TURN_W'(i_cfg.search_turn_rate)
                                : (TURN_W'(0) - TURN_W'(i_cfg.search_turn_rate));
            n_angle = w_asum[ANGLE_W] ? {ANGLE_W{1'b1}} : w_asum[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seen   <= 1'b0;
            r_angle  <= '0;
            r_dir    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_seen   <= n_seen;
                r_angle  <= n_angle;
                r_dir    <= n_dir;
                r_ovalid <= 1'b1;
            end else if (o_steer.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_lvl   <= i_scan.data.sensor_levels;
            r_ch    <= CNT_W'(CHANNELS);
            r_pos   <= CSUM_W'(POS_FIRST);
            r_sum   <= '0;
            r_count <= '0;
        end else if ((r_state == ST_PREP) && (r_ch != '0)) begin
            r_lvl <= r_lvl >> 1;
            r_ch  <= r_ch - 1'b1;
            r_pos <= r_pos + CSUM_W'(POS_STEP);
            if (r_lvl[0] == i_cfg.black_level) begin
                r_sum   <= r_sum + r_pos;
                r_count <= r_count + 1'b1;
            end
        end
        if (w_y_done) begin
            r_y <= n_y;
        end
        if (r_state == ST_CHECK) begin
            r_mag <= (w_den == '0) ? '0 : i_cfg.max_turn_rate;
        end else if ((r_state == ST_DIVT) && w_div_done) begin
            r_mag <= n_mag;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == ST_PREP))
        else $error("accepted scan did not start the channel pass");

    a_found_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.line_found) |-> (r_out.speed_out == i_cfg.forward_speed))
        else $error("found word speed differs from forward speed");

    a_turn_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.line_found) |->
            (($signed(r_out.turn_out) <= $signed({1'b0, i_cfg.max_turn_rate})) &&
             ($signed(r_out.turn_out) >= -$signed({1'b0, i_cfg.max_turn_rate}))))
        else $error("turn rate outside clamp");

    a_search_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.searching) |->
            (!r_out.line_found && (r_out.speed_out == '0) && (r_out.line_position == '0)))
        else $error("search word carries line data");
`endif

endmodule

[rtl/line_follow_steering.sv]
// sequence when the line is seen: a channel pass for the centroid, a divide for the line
// position, the multiplies, then a divide for the turn; the turn divide is skipped when
// the turn clamps or the divisor is zero, and the word follows the channel pass when lost
// flow: a scan is accepted only in the idle state, after the previous result word is
// loaded, so each scan runs alone through the bit-serial multipliers and shared divider
// reset: synchronous active low; clears control and search state, loads register defaults
// ----------------------------------------------------------------------------
// line_follow_steering
// pure pursuit steering from one line-sensor scan, with lost line search
// ----------------------------------------------------------------------------
module line_follow_steering
    import lfs_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int SENSOR_PITCH = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lfs_stream_if.sink         i_scan,
    lfs_stream_if.source       o_steer,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg w_cfg;

    lfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lfs_core #(
        .CHANNELS     (CHANNELS),
        .SENSOR_PITCH (SENSOR_PITCH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_scan  (i_scan),
        .o_steer (o_steer)
    );

endmodule

[sim/line_follow_steering_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_steering_test
// drives sensor scans into the line follower under changing register settings
// and random handshake stalls, and checks every steering word against an
// in-bench model of the centroid, pure pursuit turn and lost line search
// ----------------------------------------------------------------------------
module line_follow_steering_test;
    import lfs_pkg::*;

    localparam int CHANNELS     = 8;
    localparam int SENSOR_PITCH = 12;
    localparam int CLK_HALF     = 2;
    localparam int LATENCY      = 70;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_POS   = 2'd1,
        DIR_NEG   = 2'd2,
        DIR_SPARE = 2'd3
    } t_dir;

    class steer_scoreboard;
        t_cfg        cfg;
        bit          seen;
        int unsigned angle;
        t_dir        dir;
        t_steer      pending[$];
        int          errors;
        int          n_scans;
        int          n_found;
        int          n_search;

        function new();
            cfg      = CFG_RESET;
            seen     = 1'b0;
            angle    = 0;
            dir      = DIR_NONE;
            errors   = 0;
            n_scans  = 0;
            n_found  = 0;
            n_search = 0;
        endfunction

        function void note_scan(input logic [LEVELS_W-1:0] lv);
            int              sum;
            int              cnt;
            int              y;
            int              t;
            longint unsigned ay;
            longint unsigned num;
            longint unsigned den;
            longint unsigned mag;
            t_steer          w;
            sum = 0;
            cnt = 0;
            w   = '0;
            n_scans++;
            for (int i = 0; i < CHANNELS; i++) begin
                if (lv[i] == cfg.black_level) begin
                    sum += (2 * i - (CHANNELS - 1)) * SENSOR_PITCH * 8;
                    cnt++;
                end
            end
            if (cnt > 0) begin
                y = sum / cnt;
                if (y > Y_POS_LIM) y = Y_POS_LIM;
                if (y < -Y_NEG_LIM) y = -Y_NEG_LIM;
                ay  = (y < 0) ? -y : y;
                num = ay * 512;
                num = num * cfg.steer_gain;
                num = num * cfg.forward_speed;
                den = cfg.lookahead_mm;
                den = den * den * 256 + ay * ay;
                mag = (den == 0) ? 0 : num / den;
                if (mag > cfg.max_turn_rate) mag = cfg.max_turn_rate;
                t = (y < 0) ? -int'(mag) : int'(mag);
                seen  = 1'b1;
                angle = 0;
                if (t > 0) dir = DIR_POS;
                else if (t < 0) dir = DIR_NEG;
                w.speed_out     = cfg.forward_speed;
                w.turn_out      = TURN_W'(t);
                w.line_position = LPOS_W'(y);
                w.line_found    = 1'b1;
                n_found++;
            end else if (seen && (dir == DIR_POS || dir == DIR_NEG) &&
                         cfg.search_turn_rate != 0 && angle < cfg.search_limit) begin
                t = (dir == DIR_POS) ? int'(cfg.search_turn_rate)
                                     : -int'(cfg.search_turn_rate);
                angle += cfg.search_step;
                if (angle > 65535) angle = 65535;
                w.turn_out  = TURN_W'(t);
                w.searching = 1'b1;
                n_search++;
            end
            pending.push_back(w);
        endfunction

        function void check_word(input t_steer got);
            t_steer want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected steering word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.speed_out !== want.speed_out || got.turn_out !== want.turn_out ||
                got.line_position !== want.line_position ||
                got.line_found !== want.line_found || got.searching !== want.searching) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch at %0t: exp speed %0d turn %0d pos %0d found %b srch %b, got speed %0d turn %0d pos %0d found %b srch %b",
                             $realtime, want.speed_out, want.turn_out, want.line_position,
                             want.line_found, want.searching, got.speed_out, got.turn_out,
                             got.line_position, got.line_found, got.searching);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lfs_stream_if #(.T(t_scan))  scan_if ();
    lfs_stream_if #(.T(t_steer)) steer_if ();

    steer_scoreboard sb;
    int              send_idle;
    int              recv_idle;
    int              cycles;
    int              n_settings;

    line_follow_steering #(
        .CHANNELS     (CHANNELS),
        .SENSOR_PITCH (SENSOR_PITCH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_if),
        .o_steer (steer_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("line_follow_steering_test: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        steer_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && steer_if.valid && steer_if.ready)
            sb.check_word(steer_if.data);
    end

    function automatic logic [PDATA_W-1:0] reg_value(input t_cfg c,
                                                     input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_BLACK_LEVEL:   return PDATA_W'(c.black_level);
            REG_LOOKAHEAD:     return PDATA_W'(c.lookahead_mm);
            REG_FORWARD_SPEED: return PDATA_W'(c.forward_speed);
            REG_STEER_GAIN:    return PDATA_W'(c.steer_gain);
            REG_MAX_TURN:      return PDATA_W'(c.max_turn_rate);
            REG_SEARCH_TURN:   return PDATA_W'(c.search_turn_rate);
            REG_SEARCH_STEP:   return PDATA_W'(c.search_step);
            default:           return PDATA_W'(c.search_limit);
        endcase
    endfunction

    function automatic int unsigned pick(input int unsigned top);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 30) return top;
        return $urandom_range(top);
    endfunction

    function automatic t_cfg random_setting();
        t_cfg        c;
        int unsigned lim;
        c.black_level      = 1'($urandom_range(1));
        c.lookahead_mm     = ($urandom_range(19) == 0) ? '0 : LOOK_W'($urandom_range(1, 1023));
        c.forward_speed    = SPEED_W'(pick(4095));
        c.steer_gain       = GAIN_W'(pick(4095));
        c.max_turn_rate    = RATE_W'(pick(32767));
        c.search_turn_rate = RATE_W'(pick(32767));
        c.search_step      = STEP_W'(pick(4095));
        lim = c.search_step * $urandom_range(12);
        if (lim > 32767) lim = 32767;
        c.search_limit = ($urandom_range(1) == 1) ? RATE_W'(lim) : RATE_W'(pick(32767));
        return c;
    endfunction

    task automatic write_setting(input t_cfg c);
        for (int i = 0; i < (1 << REG_IDX_W); i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= PADDR_W'(4 * i);
            pwdata  <= reg_value(c, REG_IDX_W'(i));
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.cfg = c;
        n_settings++;
    endtask

    task automatic send_scan(input logic [LEVELS_W-1:0] lv);
        if (scan_if.valid && $urandom_range(99) < send_idle) begin
            scan_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        scan_if.valid <= 1'b1;
        scan_if.data  <= lv;
        do @(posedge i_clk); while (!scan_if.ready);
        sb.note_scan(lv);
    endtask

    task automatic wait_drain();
        scan_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    task automatic settle();
        wait_drain();
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // runs of line blobs and lost scans, with some noise between them
    task automatic run_scans(input int n, input int hold_at);
        int                  sent;
        int                  kind;
        int                  len;
        int                  w;
        int                  s;
        logic [LEVELS_W-1:0] marks;
        logic [LEVELS_W-1:0] lv;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(9);
            len  = (kind < 4) ? $urandom_range(1, 6) :
                   (kind < 7) ? $urandom_range(1, 12) : $urandom_range(1, 4);
            for (int k = 0; k < len && sent < n; k++) begin
                if (kind < 4) begin
                    w     = $urandom_range(1, 4);
                    s     = $urandom_range(0, LEVELS_W - w);
                    marks = LEVELS_W'((1 << w) - 1) << s;
                end else begin
                    marks = '0;
                end
                lv = sb.cfg.black_level ? marks : ~marks;
                if (kind >= 7) lv = LEVELS_W'($urandom);
                send_scan(lv);
                sent++;
                if (sent == hold_at) wait_drain();
            end
        end
    endtask

    localparam logic [LEVELS_W-1:0] DEFAULT_SCANS [15] = '{
        8'h00, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h18, 8'h00,
        8'h00, 8'h3C, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h7E
    };
    localparam logic [LEVELS_W-1:0] STEEP_SCANS [5] = '{
        8'hFF, 8'hE7, 8'h00, 8'hFE, 8'hFF
    };
    localparam logic [LEVELS_W-1:0] CLAMPED_SCANS [4] = '{
        8'h7F, 8'hFF, 8'hFF, 8'hFF
    };

    initial begin
        t_cfg c;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        scan_if.valid  = 1'b0;
        scan_if.data   = '0;
        steer_if.ready = 1'b0;
        cycles         = 0;
        n_settings     = 0;
        send_idle      = 33;
        recv_idle      = 79;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: never seen, centred, both edges, search after loss
        foreach (DEFAULT_SCANS[k]) send_scan(DEFAULT_SCANS[k]);

        // white line, no lookahead, zero search rate
        settle();
        c = CFG_RESET;
        c.black_level      = 1'b0;
        c.lookahead_mm     = '0;
        c.forward_speed    = '1;
        c.steer_gain       = '1;
        c.max_turn_rate    = '1;
        c.search_turn_rate = '0;
        c.search_step      = '1;
        c.search_limit     = 15'd8190;
        write_setting(c);
        foreach (STEEP_SCANS[k]) send_scan(STEEP_SCANS[k]);

        // zero clamp, full search rate until the angle hits its limit
        settle();
        c.max_turn_rate    = '0;
        c.search_turn_rate = '1;
        write_setting(c);
        foreach (CLAMPED_SCANS[k]) send_scan(CLAMPED_SCANS[k]);

        for (int ph = 0; ph < 9; ph++) begin
            settle();
            if (ph == 3) begin
                send_idle = 79;
                recv_idle = 33;
            end else if (ph == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == 2) begin
                c = '0;
            end else if (ph == 5) begin
                c = '1;
            end else begin
                c = random_setting();
            end
            write_setting(c);
            run_scans(50, (ph == 1) ? 25 : 0);
        end
        settle();

        $display("covered %0d scans over %0d register settings", sb.n_scans, n_settings);
        $display("%0d words with line found, %0d search turns, %0d mismatches",
                 sb.n_found, sb.n_search, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("line_follow_steering_test: clean");
        end else begin
            $display("line_follow_steering_test: errors");
        end
        $finish;
    end

endmodule
